### rtl/sswc_pkg.sv
package sswc_pkg;

    // Field widths of the channels and of the configuration port
    localparam int RANGE_W     = 16;
    localparam int COUNT_W     = 11;
    localparam int OUT_IDX_W   = 10;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Default build parameters
    localparam int DEF_MAX_SCAN_SAMPLES   = 1024;
    localparam int DEF_MAX_CLUSTER        = 1024;
    localparam int DEF_SINE_FRACTION_BITS = 15;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOSE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RANGE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LARGE_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_WIDTH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_TOLERANCE = 3'd4;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] RST_CLOSE_THRESHOLD = 16'd100;
    localparam logic [CFG_DATA_W-1:0] RST_MAX_RANGE       = 16'd5000;
    localparam logic [CFG_DATA_W-1:0] RST_LARGE_WIDTH     = 16'd600;
    localparam logic [CFG_DATA_W-1:0] RST_SMALL_WIDTH     = 16'd156;
    localparam logic [CFG_DATA_W-1:0] RST_WIDTH_TOLERANCE = 16'd200;

    // Target classes
    localparam logic CLASS_LARGE = 1'b0;
    localparam logic CLASS_SMALL = 1'b1;

    // Angle constants in Q30 radians: half the beam increment, pi, pi/2, 2*pi, one
    localparam longint unsigned HALF_INC_Q30 = 64'd3518692;
    localparam longint unsigned PI_Q30       = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
    localparam longint unsigned TWO_PI_Q30   = 64'd6746518852;
    localparam longint unsigned ONE_Q30      = 64'd1073741824;

    // Horner divisors of the Taylor series up to x^13
    localparam longint unsigned SINE_DIVS [6] = '{64'd156, 64'd110, 64'd72,
                                                  64'd42, 64'd20, 64'd6};

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               scan_end;
    } sample_t;

    typedef struct packed {
        logic                 target_class;
        logic [RANGE_W-1:0]   width_mm;
        logic [COUNT_W-1:0]   member_count;
        logic [OUT_IDX_W-1:0] first_index;
        logic [OUT_IDX_W-1:0] last_index;
    } target_t;

    // Sine table entry k: sin(k*inc/2) rounded to frac fraction bits.
    // Bit 31 flags a negative sine, the magnitude sits in the low bits.
    function automatic logic [31:0] sine_entry(input int unsigned k, input int unsigned frac);
        longint unsigned a;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned r;
        logic            neg;
        logic [31:0]     res;
        a   = (64'(k) * HALF_INC_Q30) % TWO_PI_Q30;
        neg = 1'b0;
        if (a >= PI_Q30)
        begin
            neg = 1'b1;
            a   = a - PI_Q30;
        end
        if (a > HALF_PI_Q30)
        begin
            a = PI_Q30 - a;
        end
        x2 = (a * a) >> 30;
        t  = ONE_Q30;
        for (int i = 0; i < 6; i++)
        begin
            t = ONE_Q30 - ((x2 * t) >> 30) / SINE_DIVS[i];
        end
        s   = (a * t) >> 30;
        r   = (s + (64'd1 << (29 - frac))) >> (30 - frac);
        res = {neg, r[30:0]};
        return res;
    endfunction

endpackage

### rtl/scan_segment_width_classifier.sv
// Channel  | Signals                              | Direction | Transfer when
// ---------+--------------------------------------+-----------+---------------------------
// sample   | sample_valid, sample_stall, sample   | in        | sample_valid & !sample_stall
// target   | target_valid, target_stall, target   | out       | target_valid & !target_stall
// cfg      | cfg_write, cfg_index, cfg_data       | in        | cfg_write
//
// One sample is taken every cycle unless sample_stall is high; cluster tracking is done at the sample transfer.
// A closing cluster runs through four register stages (sine ROM read, multiply,
// width rounding, classification) before its result shows on the target channel.
// Stalls only back up through occupied stages; sample_stall rises when the ROM stage
// is full and cannot move on.
// Reset (rst_n, async, active low) clears the cluster state and restores the register defaults.
module scan_segment_width_classifier
    import sswc_pkg::*;
#(
    parameter int MAX_SCAN_SAMPLES   = DEF_MAX_SCAN_SAMPLES,
    parameter int MAX_CLUSTER        = DEF_MAX_CLUSTER,
    parameter int SINE_FRACTION_BITS = DEF_SINE_FRACTION_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample,
    output logic                   target_valid,
    input  logic                   target_stall,
    output target_t                target,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW   = $clog2(MAX_SCAN_SAMPLES);
    localparam int CW   = $clog2(MAX_CLUSTER + 1);
    localparam int AW   = $clog2(MAX_CLUSTER);
    localparam int SW   = SINE_FRACTION_BITS + 2;   // neg flag + magnitude
    localparam int MW   = SINE_FRACTION_BITS + 1;   // magnitude up to 1.0
    localparam int PW   = RANGE_W + MW;             // range * sine
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SCAN_SAMPLES - 1);
    localparam logic [CW-1:0] CL_MAX   = CW'(MAX_CLUSTER);
    localparam logic [PW+1:0] ROUND_ADD = (PW + 2)'(1) << (SINE_FRACTION_BITS - 1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] close_thr_reg;
    logic [CFG_DATA_W-1:0] max_range_reg;
    logic [CFG_DATA_W-1:0] large_width_reg;
    logic [CFG_DATA_W-1:0] small_width_reg;
    logic [CFG_DATA_W-1:0] width_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_thr_reg   <= RST_CLOSE_THRESHOLD;
            max_range_reg   <= RST_MAX_RANGE;
            large_width_reg <= RST_LARGE_WIDTH;
            small_width_reg <= RST_SMALL_WIDTH;
            width_tol_reg   <= RST_WIDTH_TOLERANCE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLOSE_THRESHOLD: close_thr_reg   <= cfg_data;
                CFG_MAX_RANGE:       max_range_reg   <= cfg_data;
                CFG_LARGE_WIDTH:     large_width_reg <= cfg_data;
                CFG_SMALL_WIDTH:     small_width_reg <= cfg_data;
                CFG_WIDTH_TOLERANCE: width_tol_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sine ROM, built at elaboration
    logic [SW-1:0] sine_rom [MAX_CLUSTER];

    for (genvar k = 0; k < MAX_CLUSTER; k++)
    begin : g_rom
        localparam logic [31:0] ENTRY = sine_entry(k, SINE_FRACTION_BITS);
        assign sine_rom[k] = {ENTRY[31], ENTRY[MW-1:0]};
    end

    // Pipeline occupancy and advance
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, target_valid_reg;
    logic en1, en2, en3, en_out;
    logic target_hit;

    assign en_out       = !target_valid_reg || !target_stall;
    assign en3          = !s3_valid_reg || en_out;
    assign en2          = !s2_valid_reg || en3;
    assign en1          = !s1_valid_reg || en2;
    assign sample_stall = !en1;

    logic accept;
    assign accept = sample_valid && en1;

    // Cluster tracking state
    logic [RANGE_W-1:0] prev_range_reg, prev_range_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [IW-1:0]      sample_index_reg, sample_index_next;
    logic [CW-1:0]      cluster_size_reg, cluster_size_next;
    logic [IW-1:0]      cluster_start_reg, cluster_start_next;
    logic [IW-1:0]      cluster_last_reg, cluster_last_next;
    logic [RANGE_W-1:0] cluster_range_reg, cluster_range_next;

    logic [IW-1:0]      prev_idx;
    logic [RANGE_W-1:0] range_diff;
    logic               join_prev;
    logic               close_fire;
    logic [CW-1:0]      size_dec;
    logic [AW-1:0]      rom_addr;

    // Neighbor test, join, close decision
    always_comb
    begin
        prev_idx   = (sample_index_reg == '0) ? LAST_IDX : sample_index_reg - IW'(1);
        range_diff = (prev_range_reg > sample.range_mm) ? prev_range_reg - sample.range_mm
                                                        : sample.range_mm - prev_range_reg;
        join_prev  = prev_valid_reg && (prev_range_reg < max_range_reg)
                     && (sample.range_mm < max_range_reg) && (range_diff <= close_thr_reg);

        cluster_size_next  = cluster_size_reg;
        cluster_start_next = cluster_start_reg;
        cluster_last_next  = cluster_last_reg;
        cluster_range_next = cluster_range_reg;
        if (join_prev)
        begin
            if (cluster_size_reg == '0)
            begin
                cluster_start_next = prev_idx;
            end
            if (cluster_size_reg < CL_MAX)
            begin
                cluster_size_next = cluster_size_reg + CW'(1);
            end
            cluster_last_next  = prev_idx;
            cluster_range_next = prev_range_reg;
        end

        // a break or the scan end closes the (possibly just extended) cluster
        close_fire = (cluster_size_next != '0)
                     && ((prev_valid_reg && !join_prev) || sample.scan_end);
        size_dec   = cluster_size_next - CW'(1);
        rom_addr   = size_dec[AW-1:0];

        if (close_fire || sample.scan_end)
        begin
            cluster_size_next = '0;
        end

        if (sample.scan_end)
        begin
            prev_valid_next   = 1'b0;
            prev_range_next   = '0;
            sample_index_next = '0;
        end
        else
        begin
            prev_valid_next   = 1'b1;
            prev_range_next   = sample.range_mm;
            sample_index_next = (sample_index_reg == LAST_IDX) ? '0
                                                                : sample_index_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_range_reg    <= '0;
            prev_valid_reg    <= 1'b0;
            sample_index_reg  <= '0;
            cluster_size_reg  <= '0;
            cluster_start_reg <= '0;
            cluster_last_reg  <= '0;
            cluster_range_reg <= '0;
        end
        else if (accept)
        begin
            prev_range_reg    <= prev_range_next;
            prev_valid_reg    <= prev_valid_next;
            sample_index_reg  <= sample_index_next;
            cluster_size_reg  <= cluster_size_next;
            cluster_start_reg <= cluster_start_next;
            cluster_last_reg  <= cluster_last_next;
            cluster_range_reg <= cluster_range_next;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            target_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= sample_valid && close_fire;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                target_valid_reg <= s3_valid_reg && target_hit;
            end
        end
    end

    // Stage 1: closing cluster and its sine
    logic [SW-1:0]      s1_sine_reg;
    logic [RANGE_W-1:0] s1_range_reg;
    logic [CW-1:0]      s1_size_reg;
    logic [IW-1:0]      s1_start_reg, s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_sine_reg  <= sine_rom[rom_addr];
            s1_range_reg <= cluster_range_next;
            // size of the closing cluster, taken before it empties
            s1_size_reg  <= size_dec + CW'(1);
            s1_start_reg <= cluster_start_next;
            s1_last_reg  <= cluster_last_next;
        end
    end

    // Stage 2: range times sine
    logic [PW-1:0] s2_prod_reg;
    logic          s2_neg_reg;
    logic [CW-1:0] s2_size_reg;
    logic [IW-1:0] s2_start_reg, s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_prod_reg  <= PW'(s1_range_reg) * PW'(s1_sine_reg[MW-1:0]);
            s2_neg_reg   <= s1_sine_reg[SW-1];
            s2_size_reg  <= s1_size_reg;
            s2_start_reg <= s1_start_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Stage 3: double, round, saturate; a negative sine gives zero width
    logic [PW+1:0]      round_sum;
    logic [PW+1:0]      round_shr;
    logic [RANGE_W-1:0] width_next;

    always_comb
    begin
        round_sum = {1'b0, s2_prod_reg, 1'b0} + ROUND_ADD;
        round_shr = round_sum >> SINE_FRACTION_BITS;
        if (s2_neg_reg)
        begin
            width_next = '0;
        end
        else if (|round_shr[PW+1:RANGE_W])
        begin
            width_next = '1;
        end
        else
        begin
            width_next = round_shr[RANGE_W-1:0];
        end
    end

    logic [RANGE_W-1:0] s3_width_reg;
    logic [CW-1:0]      s3_size_reg;
    logic [IW-1:0]      s3_start_reg, s3_last_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_width_reg <= width_next;
            s3_size_reg  <= s2_size_reg;
            s3_start_reg <= s2_start_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // Stage 4: class match, large first
    logic [RANGE_W-1:0] diff_large, diff_small;
    logic               hit_large, hit_small;
    logic [31:0]        size_ext, start_ext, last_ext;
    target_t            target_next;

    always_comb
    begin
        diff_large = (s3_width_reg > large_width_reg) ? s3_width_reg - large_width_reg
                                                      : large_width_reg - s3_width_reg;
        diff_small = (s3_width_reg > small_width_reg) ? s3_width_reg - small_width_reg
                                                      : small_width_reg - s3_width_reg;
        hit_large  = diff_large <= width_tol_reg;
        hit_small  = diff_small <= width_tol_reg;
        target_hit = hit_large || hit_small;

        size_ext  = 32'(s3_size_reg);
        start_ext = 32'(s3_start_reg);
        last_ext  = 32'(s3_last_reg);

        target_next.target_class = hit_large ? CLASS_LARGE : CLASS_SMALL;
        target_next.width_mm     = s3_width_reg;
        target_next.member_count = size_ext[COUNT_W-1:0];
        target_next.first_index  = start_ext[OUT_IDX_W-1:0];
        target_next.last_index   = last_ext[OUT_IDX_W-1:0];
    end

    target_t target_reg;

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            target_reg <= target_next;
        end
    end

    assign target_valid = target_valid_reg;
    assign target       = target_reg;

    // Checks
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && target_valid_reg)
        else $error("sample stalled with a free pipeline slot");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cluster_size_reg <= CL_MAX)
        else $error("cluster size beyond its saturation limit");

    a_scan_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.scan_end) |=>
            !prev_valid_reg && sample_index_reg == '0 && cluster_size_reg == '0)
        else $error("scan end did not restart the scan state");

    a_close_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && close_fire) |=> s1_valid_reg && cluster_size_reg == '0)
        else $error("closed cluster not emptied or not handed on");

endmodule
